// File: hdl/assert_macros.svh
// Assertion macros shared by the line rasterizer RTL.
// Included by every module that carries concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, but it also holds while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/dlr_pkg.sv
// Shared types and constants of the DDA line rasterizer.
// No dependencies; imported by dlr_divider and dda_line_rasterizer.
package dlr_pkg;

  localparam int COLOR_BITS = 24;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'h0000FF;

  // Operation codes carried in the input tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic {
    CTL_IDLE,
    CTL_DIVIDE
  } ctl_state_e;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

endpackage

// File: hdl/dlr_divider.sv
// Radix-2 restoring divider for the slope: quotient = (dividend << FRAC_BITS) / divisor.
// Requires dividend <= divisor; depends on dlr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlr_divider #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] dividend_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [FRAC_BITS:0]    quotient_o
);
  import dlr_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  div_state_e            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] div_q, div_d;
  logic [FRAC_BITS:0]    quo_q, quo_d;
  logic                  zero_q, zero_d;
  logic                  done_q, done_d;

  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS:0]   diff;
  logic                  ge;
  logic                  int_bit;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};
  assign int_bit = dividend_i >= divisor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rem_d   = rem_q;
    div_d   = div_q;
    quo_d   = quo_q;
    zero_d  = zero_q;
    done_d  = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          // The integer bit is one only when both magnitudes are equal.
          div_d   = divisor_i;
          zero_d  = divisor_i == '0;
          quo_d   = {{FRAC_BITS{1'b0}}, int_bit};
          rem_d   = int_bit ? (dividend_i - divisor_i) : dividend_i;
          count_d = CNT_W'(FRAC_BITS);
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_d   = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
        quo_d   = {quo_q[FRAC_BITS-1:0], ge};
        count_d = count_q - 1'b1;
        if (count_q == CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  assign done_o     = done_q;
  assign quotient_o = zero_q ? '0 : quo_q;

  `ASSERT_CLK(a_div_range, done_o |-> (quotient_o <= ((FRAC_BITS+1)'(1) << FRAC_BITS)),
              "slope quotient exceeds one")
  `ASSERT_CLK(a_div_no_restart, (state_q == DIV_RUN) |-> !start_i,
              "divider restarted while running")

endmodule

// File: hdl/dda_line_rasterizer.sv
// DDA line rasterizer: input streaming, slope division sequencing, pixel stepping, output register.
// Depends on dlr_pkg, dlr_divider and assert_macros.svh.
//
// Usage:
//   Input stream (s_axis): tuser selects the operation, 0 loads a line from the endpoints
//   in tdata, 1 requests the next pixel of the loaded line. A load gives no output.
//   Output stream (m_axis): one transaction per pixel request with the pixel coordinates
//   and color in tdata, tuser high when a pixel was produced (low, with all fields zero,
//   when no line is active) and tlast on the end-point pixel of the line.
//   Configuration: cfg_data_i is written to the line color when cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while the block is idle.
//   Timing: a load occupies the block while the radix-2 slope divider, which retires one
//   quotient bit per cycle, runs; s_axis_tready_o is low meanwhile.
//   The result of an accepted pixel request sits in the output register in the next cycle,
//   so requests stream at one per cycle while the receiver keeps up and no load is running.
//   If the receiver stalls, the result holds in the output register and new requests
//   are refused until it is taken. Loads are also refused in that case.
//   Reset: no line is active, the color returns to 0x0000FF, the output is empty.
`include "assert_macros.svh"

module dda_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid_i,
  output logic                                            s_axis_tready_o,
  // x_start, y_start, x_end, y_end from bit 0 up, zero padded to bytes.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]               s_axis_tdata_i,
  // operation.
  input  logic                                            s_axis_tuser_i,
  output logic                                            m_axis_tvalid_o,
  input  logic                                            m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color from bit 0 up, zero padded to bytes.
  output logic [((2*COORD_BITS+dlr_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // pixel_valid.
  output logic                                            m_axis_tuser_o,
  output logic                                            m_axis_tlast_o,
  input  logic                                            cfg_valid_i,
  output logic                                            cfg_ready_o,
  input  logic [dlr_pkg::COLOR_BITS-1:0]                  cfg_data_i
);
  import dlr_pkg::*;

  localparam int OUT_W   = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;
  localparam int ACC_W   = COORD_BITS + FRAC_BITS;
  localparam int SLOPE_W = FRAC_BITS + 2;

  ctl_state_e state_q, state_d;

  logic [COLOR_BITS-1:0] color_q;
  logic [COORD_BITS-1:0] major_pos_q;
  logic [COORD_BITS-1:0] major_end_q;
  logic [ACC_W-1:0]      acc_q;
  logic [SLOPE_W-1:0]    slope_q;
  logic                  steep_q;
  logic                  backward_q;
  logic                  negative_q;
  logic                  active_q;

  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;
  logic                  out_flag_q;
  logic                  out_last_q;

  logic                  in_fire;
  logic                  load_fire;
  logic                  pixel_fire;
  logic                  div_start;
  logic                  div_done;
  logic [FRAC_BITS:0]    quotient;

  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  steep_new;
  logic [COORD_BITS-1:0] amaj, amin;
  logic [COORD_BITS-1:0] ms, me, ns, ne;

  logic [ACC_W-1:0]      rounded;
  logic [COORD_BITS-1:0] minor;
  logic                  is_last;
  logic [SLOPE_W-1:0]    slope_new;

  assign xs = s_axis_tdata_i[0*COORD_BITS +: COORD_BITS];
  assign ys = s_axis_tdata_i[1*COORD_BITS +: COORD_BITS];
  assign xe = s_axis_tdata_i[2*COORD_BITS +: COORD_BITS];
  assign ye = s_axis_tdata_i[3*COORD_BITS +: COORD_BITS];

  assign adx       = (xe >= xs) ? xe - xs : xs - xe;
  assign ady       = (ye >= ys) ? ye - ys : ys - ye;
  assign steep_new = !(ady < adx);
  assign ms        = steep_new ? ys : xs;
  assign me        = steep_new ? ye : xe;
  assign ns        = steep_new ? xs : ys;
  assign ne        = steep_new ? xe : ye;
  assign amaj      = steep_new ? ady : adx;
  assign amin      = steep_new ? adx : ady;

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_fire  = in_fire && (s_axis_tuser_i == OP_LOAD);
  assign pixel_fire = in_fire && (s_axis_tuser_i == OP_PIXEL);

  // Minor coordinate rounded half-up from the fixed-point accumulator.
  assign rounded = acc_q + (ACC_W'(1) << (FRAC_BITS - 1));
  assign minor   = rounded[ACC_W-1:FRAC_BITS];
  assign is_last = major_pos_q == major_end_q;

  assign slope_new = negative_q ? (SLOPE_W'(0) - {1'b0, quotient}) : {1'b0, quotient};

  dlr_divider #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(amin),
    .divisor_i (amaj),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    unique case (state_q)
      CTL_IDLE: begin
        s_axis_tready_o = !out_valid_q || m_axis_tready_i;
        if (load_fire) begin
          div_start = 1'b1;
          state_d   = CTL_DIVIDE;
        end
      end
      CTL_DIVIDE: begin
        if (div_done) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= COLOR_RESET;
      major_pos_q <= '0;
      major_end_q <= '0;
      acc_q       <= '0;
      slope_q     <= '0;
      steep_q     <= 1'b0;
      backward_q  <= 1'b0;
      negative_q  <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_fire) begin
        major_pos_q <= ms;
        major_end_q <= me;
        acc_q       <= {ns, {FRAC_BITS{1'b0}}};
        steep_q     <= steep_new;
        backward_q  <= me < ms;
        negative_q  <= ne < ns;
        active_q    <= 1'b0;
      end
      if (state_q == CTL_DIVIDE && div_done) begin
        slope_q  <= slope_new;
        active_q <= 1'b1;
      end
      if (pixel_fire) begin
        out_valid_q <= 1'b1;
        if (active_q) begin
          if (is_last) begin
            active_q <= 1'b0;
          end else begin
            major_pos_q <= backward_q ? major_pos_q - 1'b1 : major_pos_q + 1'b1;
            acc_q       <= acc_q + {{(ACC_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
          end
        end
      end
    end
  end

  // Result payload; a request with no active line returns all zeros.
  always_ff @(posedge clk_i) begin
    if (pixel_fire) begin
      if (active_q) begin
        out_data_q <= OUT_W'({color_q,
                              steep_q ? major_pos_q : minor,
                              steep_q ? minor : major_pos_q});
        out_flag_q <= 1'b1;
        out_last_q <= is_last;
      end else begin
        out_data_q <= '0;
        out_flag_q <= 1'b0;
        out_last_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_flag_q;
  assign m_axis_tlast_o  = out_last_q;
  assign cfg_ready_o     = 1'b1;

  `ASSERT_CLK(a_no_input_while_dividing, (state_q == CTL_DIVIDE) |-> !s_axis_tready_o,
              "input accepted during slope division")
  `ASSERT_CLK(a_done_only_dividing, div_done |-> (state_q == CTL_DIVIDE),
              "divider finished outside a load")
  `ASSERT_CLK(a_last_has_pixel, (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o,
              "last flag on a transaction without a pixel")
  `ASSERT_CLK(a_active_after_load, (state_q == CTL_DIVIDE && div_done) |=> active_q,
              "line not active after load completed")

endmodule
